@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define THCB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, on the block's own clock and reset names.
`define THCB_ASSERT_CR(lbl, prop, msg) `THCB_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/thcb_pkg.sv @@
package thcb_pkg;

  localparam int unsigned MaxSymbols = 256;
  localparam int unsigned MaxDepth   = 32;
  localparam int unsigned CountBits  = 20;
  localparam int unsigned SymW       = 8;
  localparam int unsigned LeafAw     = 8;
  localparam int unsigned NodeAw     = 9;
  localparam int unsigned NodeSlots  = 512;
  localparam int unsigned WeightW    = 28;
  localparam int unsigned DigitW     = 2;
  localparam int unsigned DigitsW    = 2 * MaxDepth;
  localparam int unsigned LenW       = 6;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [SymW-1:0]     symbol;
    logic [CountBits-1:0] count;
    logic                last_leaf;
    logic [LeafAw-1:0]   entry_index;
  } in_t;

  typedef struct packed {
    logic [SymW-1:0]    out_symbol;
    logic [LenW-1:0]    code_length;
    logic [DigitsW-1:0] code_digits;
    logic               overflow;
    logic               entry_valid;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD_INIT,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_CHILD,
    ST_NODE,
    ST_WALK_RD,
    ST_WALK_UP,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic load_leaf;
    logic read_start;
    logic build_init;
    logic scan_clear;
    logic finish;
    logic scan_step;
    logic child_wr;
    logic node_wr;
    logic walk_rd;
    logic walk_up;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_is_read;
    logic in_last;
    logic read_ok;
    logic queued_gt1;
    logic scan_last;
    logic child_last;
    logic at_root;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/thcb_ctrl.sv @@
module thcb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  thcb_pkg::sts_t sts_i,
  output thcb_pkg::cmd_t cmd_o
);
  import thcb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.in_is_read) begin
            state_d = sts_i.read_ok ? ST_WALK_RD : ST_RESULT;
          end else if (sts_i.in_last) begin
            state_d = ST_BUILD_INIT;
          end
        end
      end
      ST_BUILD_INIT: state_d = ST_CHECK;
      ST_CHECK:      state_d = sts_i.queued_gt1 ? ST_SCAN : ST_IDLE;
      ST_SCAN:       state_d = sts_i.scan_last ? ST_SCAN_TAIL : ST_SCAN;
      ST_SCAN_TAIL:  state_d = ST_CHILD;
      ST_CHILD:      state_d = sts_i.child_last ? ST_NODE : ST_CHILD;
      ST_NODE:       state_d = ST_CHECK;
      ST_WALK_RD:    state_d = sts_i.at_root ? ST_RESULT : ST_WALK_UP;
      ST_WALK_UP:    state_d = ST_WALK_RD;
      ST_RESULT:     state_d = sts_i.out_free ? ST_IDLE : ST_RESULT;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.load_leaf   = in_valid_i & ~sts_i.in_is_read;
        cmd_o.read_start  = in_valid_i & sts_i.in_is_read;
      end
      ST_BUILD_INIT: cmd_o.build_init = 1'b1;
      ST_CHECK: begin
        cmd_o.scan_clear = 1'b1;
        cmd_o.finish     = ~sts_i.queued_gt1;
      end
      ST_SCAN:      cmd_o.scan_step = 1'b1;
      ST_SCAN_TAIL: ;
      ST_CHILD:     cmd_o.child_wr = 1'b1;
      ST_NODE:      cmd_o.node_wr = 1'b1;
      ST_WALK_RD:   cmd_o.walk_rd = ~sts_i.at_root;
      ST_WALK_UP:   cmd_o.walk_up = 1'b1;
      ST_RESULT:    cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/thcb_dp.sv @@
module thcb_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  thcb_pkg::in_t  in_data_i,
  input  thcb_pkg::cmd_t cmd_i,
  output thcb_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output thcb_pkg::out_t out_data_o
);
  import thcb_pkg::*;

  // Storage. A node word is {in-queue flag, weight}; a parent word is {parent, digit}.
  logic [SymW-1:0]          leaf_mem [MaxSymbols];
  logic [WeightW:0]         node_mem [NodeSlots];
  logic [NodeAw+DigitW-1:0] par_mem  [NodeSlots];

  logic [NodeAw-1:0]        leaf_cnt_q, node_cnt_q, queued_q, root_q;
  logic                     built_q;
  logic [NodeAw-1:0]        scan_ptr_q, rd_idx_q;
  logic                     rd_vld_q;
  logic [WeightW:0]         nd_rd_q;
  logic [WeightW-1:0]       selw_q [3];
  logic [NodeAw-1:0]        seli_q [3];
  logic [2:0]               selv_q;
  logic [1:0]               kid_q;
  logic [WeightW-1:0]       sum_q;
  logic [NodeAw-1:0]        walk_q, depth_q;
  logic [DigitsW-1:0]       digits_q;
  logic [NodeAw+DigitW-1:0] par_rd_q;
  logic [SymW-1:0]          sym_rd_q;
  logic                     res_ok_q;
  logic                     out_vld_q;
  out_t                     out_q;

  logic [NodeAw-1:0]        lc_eff;
  logic                     lc_room;
  logic                     pad;
  logic [NodeAw-1:0]        padded;
  logic                     ovf;
  logic [WeightW-1:0]       cand_w;
  logic                     cand_q;

  assign lc_eff  = built_q ? '0 : leaf_cnt_q;
  assign lc_room = lc_eff < NodeAw'(MaxSymbols);
  assign pad     = ~leaf_cnt_q[0];
  assign padded  = leaf_cnt_q + NodeAw'(pad);
  assign ovf     = depth_q > NodeAw'(MaxDepth);
  assign cand_w  = nd_rd_q[WeightW-1:0];
  assign cand_q  = rd_vld_q & nd_rd_q[WeightW];

  assign sts_o.in_is_read = in_data_i.opcode == OP_READ;
  assign sts_o.in_last    = in_data_i.last_leaf;
  assign sts_o.read_ok    = built_q & ({1'b0, in_data_i.entry_index} < leaf_cnt_q);
  assign sts_o.queued_gt1 = queued_q > NodeAw'(1);
  assign sts_o.scan_last  = scan_ptr_q == node_cnt_q - NodeAw'(1);
  assign sts_o.child_last = kid_q == 2'd2;
  assign sts_o.at_root    = walk_q == root_q;
  assign sts_o.out_free   = ~out_vld_q | out_ready_i;

  // Memories: one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_leaf && lc_room) begin
      leaf_mem[lc_eff[LeafAw-1:0]] <= in_data_i.symbol;
    end
    if (cmd_i.read_start) begin
      sym_rd_q <= leaf_mem[in_data_i.entry_index];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_leaf && lc_room) begin
      node_mem[lc_eff] <= {1'b1, WeightW'(in_data_i.count)};
    end else if (cmd_i.build_init && pad) begin
      node_mem[leaf_cnt_q] <= {1'b1, {WeightW{1'b0}}};
    end else if (cmd_i.child_wr) begin
      node_mem[seli_q[kid_q]] <= {1'b0, selw_q[kid_q]};
    end else if (cmd_i.node_wr) begin
      node_mem[node_cnt_q] <= {1'b1, sum_q};
    end
    if (cmd_i.scan_step) begin
      nd_rd_q <= node_mem[scan_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.child_wr) begin
      par_mem[seli_q[kid_q]] <= {node_cnt_q, kid_q};
    end
    if (cmd_i.walk_rd) begin
      par_rd_q <= par_mem[walk_q];
    end
  end

  // Build control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_cnt_q <= '0;
      node_cnt_q <= '0;
      queued_q   <= '0;
      root_q     <= '0;
      built_q    <= 1'b0;
      scan_ptr_q <= '0;
      rd_vld_q   <= 1'b0;
      selv_q     <= '0;
      kid_q      <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
      if (cmd_i.load_leaf) begin
        built_q    <= 1'b0;
        leaf_cnt_q <= lc_eff + NodeAw'(lc_room);
      end
      if (cmd_i.build_init) begin
        node_cnt_q <= padded;
        queued_q   <= padded;
      end
      if (cmd_i.finish) begin
        root_q  <= node_cnt_q - NodeAw'(1);
        built_q <= 1'b1;
      end
      if (cmd_i.scan_clear) begin
        scan_ptr_q <= '0;
        selv_q     <= '0;
        kid_q      <= '0;
      end
      if (cmd_i.scan_step) begin
        scan_ptr_q <= scan_ptr_q + NodeAw'(1);
      end
      // Keep the three lightest queued nodes, earlier index winning ties.
      if (cand_q) begin
        if (!selv_q[0] || cand_w < selw_q[0]) begin
          selv_q <= {selv_q[1], selv_q[0], 1'b1};
        end else if (!selv_q[1] || cand_w < selw_q[1]) begin
          selv_q <= {selv_q[1], 1'b1, selv_q[0]};
        end else if (!selv_q[2] || cand_w < selw_q[2]) begin
          selv_q[2] <= 1'b1;
        end
      end
      if (cmd_i.child_wr) begin
        kid_q <= kid_q + 2'd1;
      end
      if (cmd_i.node_wr) begin
        node_cnt_q <= node_cnt_q + NodeAw'(1);
        queued_q   <= queued_q - NodeAw'(2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_ptr_q;
    if (cand_q) begin
      if (!selv_q[0] || cand_w < selw_q[0]) begin
        selw_q[2] <= selw_q[1];
        seli_q[2] <= seli_q[1];
        selw_q[1] <= selw_q[0];
        seli_q[1] <= seli_q[0];
        selw_q[0] <= cand_w;
        seli_q[0] <= rd_idx_q;
      end else if (!selv_q[1] || cand_w < selw_q[1]) begin
        selw_q[2] <= selw_q[1];
        seli_q[2] <= seli_q[1];
        selw_q[1] <= cand_w;
        seli_q[1] <= rd_idx_q;
      end else if (!selv_q[2] || cand_w < selw_q[2]) begin
        selw_q[2] <= cand_w;
        seli_q[2] <= rd_idx_q;
      end
    end
    if (cmd_i.scan_clear) begin
      sum_q <= '0;
    end else if (cmd_i.child_wr) begin
      sum_q <= sum_q + selw_q[kid_q];
    end
  end

  // Code walk from the leaf up to the root; digits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_start) begin
      walk_q   <= {1'b0, in_data_i.entry_index};
      depth_q  <= '0;
      digits_q <= '0;
      res_ok_q <= sts_o.read_ok;
    end else if (cmd_i.walk_up) begin
      walk_q   <= par_rd_q[NodeAw+DigitW-1:DigitW];
      depth_q  <= depth_q + NodeAw'(1);
      digits_q <= {digits_q[DigitsW-DigitW-1:0], par_rd_q[DigitW-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (res_ok_q) begin
        out_q.out_symbol  <= sym_rd_q;
        out_q.code_length <= ovf ? LenW'(MaxDepth) : depth_q[LenW-1:0];
        out_q.code_digits <= digits_q;
        out_q.overflow    <= ovf;
        out_q.entry_valid <= 1'b1;
      end else begin
        out_q <= '0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/ternary_huffman_code_builder_core.sv @@
// Each load request is accepted while the core is idle. A load marked last starts the
// build, a series of merges each paced by a single-port scan of the node memory.
// A valid read request walks the parent memory from the leaf up to the root; an invalid
// one goes straight to the result. Both wait while the result register stays full.
// Reset is asynchronous and active low; it clears control state only, no memory pass.
module ternary_huffman_code_builder_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  thcb_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output thcb_pkg::out_t out_data_o
);
  import thcb_pkg::*;

  // The controller sequences loads, the merge loop and the code walk.
  // The datapath owns the leaf, node and parent memories and the result register.
  cmd_t cmd;
  sts_t sts;

  thcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Each merge scans every node created so far, keeping the three lightest queued
  // ones, then writes three child links and the new parent node.
  thcb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/thcb_checker.sv @@
`include "assert_macros.svh"

module thcb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input thcb_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input thcb_pkg::out_t out_data_o
);
  import thcb_pkg::*;

  `THCB_ASSERT_CR(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)), "result changed while stalled")
  `THCB_ASSERT_CR(a_invalid_zero, (out_valid_o && !out_data_o.entry_valid) |-> (out_data_o == '0), "invalid read result not zero")
  `THCB_ASSERT_CR(a_ovf_len, (out_valid_o && out_data_o.overflow) |-> (out_data_o.code_length == LenW'(MaxDepth)), "overflow without full length")
  `THCB_ASSERT_CR(a_read_busy, (in_valid_i && in_ready_o && in_data_i.opcode == OP_READ) |=> !in_ready_o, "request taken during a read")

endmodule

bind ternary_huffman_code_builder_core thcb_checker u_thcb_checker (.*);
